FILE: sv/intsort_pkg.sv
// ----------------------------------------------------------------------------
// intsort_pkg: shared types and constants of the integer sorter
//
// Holds the default sizes, the port width of the value fields, the sequencer
// state type and the control group that the sequencer hands to the output
// register.
// ----------------------------------------------------------------------------
`default_nettype none

package intsort_pkg;

	// Default number of elements held in the store.
	localparam int CAPACITY_DEF = 64;

	// Default width of a stored element.
	localparam int VALUE_BITS_DEF = 32;

	// Width of the value fields on the ports.
	localparam int PORT_BITS = 32;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_PLACE,
		ST_EMIT_RD,
		ST_EMIT
	} state_t;

	// Control group for loading the output register.
	typedef struct packed {
		logic load;
		logic fin;
		logic drop;
	} emit_t;

endpackage

`default_nettype wire

FILE: sv/intsort_store.sv
// ----------------------------------------------------------------------------
// intsort_store: element store of the integer sorter
//
// Single write port and single read port with registered read data. The read
// data holds its value while no read is requested.
// ----------------------------------------------------------------------------
`default_nettype none

module intsort_store #(
	parameter int DEPTH = intsort_pkg::CAPACITY_DEF,
	parameter int WIDTH = intsort_pkg::VALUE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

FILE: sv/intsort_seq.sv
// ----------------------------------------------------------------------------
// intsort_seq: sequencer and compare unit of the integer sorter
//
// Inserts each element into its sorted place by walking down the store one
// entry per cycle, shifting larger entries up by one, then after the final
// element streams the sorted list out one entry per cycle while out_free is set.
// ----------------------------------------------------------------------------
`default_nettype none

module intsort_seq #(
	parameter int CAPACITY   = intsort_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = intsort_pkg::VALUE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [intsort_pkg::PORT_BITS-1:0] value,
	input  wire logic                                 last,
	input  wire logic                                 out_free,
	output intsort_pkg::emit_t                        emit,
	output logic             [VALUE_BITS-1:0]         emit_data
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int MW = (VALUE_BITS > intsort_pkg::PORT_BITS) ?
		VALUE_BITS : intsort_pkg::PORT_BITS;

	intsort_pkg::state_t state_q, state_d;
	logic [CW-1:0]         count_q, count_d;
	logic [AW-1:0]         pos_q, pos_d;
	logic [AW-1:0]         idx_q, idx_d;
	logic [VALUE_BITS-1:0] v_q, v_d;
	logic                  last_q, last_d;
	logic                  ovf_q, ovf_d;

	logic                  wr_en;
	logic [AW-1:0]         wr_addr;
	logic [VALUE_BITS-1:0] wr_data;
	logic                  rd_en;
	logic [AW-1:0]         rd_addr;
	logic [VALUE_BITS-1:0] rd_data;

	logic [MW-1:0]         in_wide;
	logic [VALUE_BITS-1:0] v_in;
	logic [VALUE_BITS-1:0] key_rd;
	logic [VALUE_BITS-1:0] key_v;
	logic                  gt;
	logic                  accept;
	logic                  full;
	logic                  fin;
	logic [CW-1:0]         last_idx;

	intsort_store #(
		.DEPTH (CAPACITY),
		.WIDTH (VALUE_BITS)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Bring the port value to the stored width with zero fill.
	assign in_wide = MW'($unsigned(value));
	assign v_in    = in_wide[VALUE_BITS-1:0];

	// Shared compare unit: flipping the sign bit gives an unsigned order key.
	assign key_rd = {~rd_data[VALUE_BITS-1], rd_data[VALUE_BITS-2:0]};
	assign key_v  = {~v_q[VALUE_BITS-1], v_q[VALUE_BITS-2:0]};
	assign gt     = key_rd > key_v;

	assign in_stall = (state_q != intsort_pkg::ST_IDLE);
	assign accept   = in_valid && (state_q == intsort_pkg::ST_IDLE);
	assign full     = (count_q == CW'(CAPACITY));
	assign last_idx = count_q - CW'(1);
	assign fin      = (CW'(idx_q) == last_idx);

	assign emit_data = rd_data;

	// State and control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= intsort_pkg::ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
			pos_q   <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			ovf_q   <= ovf_d;
			last_q  <= last_d;
			pos_q   <= pos_d;
		end
	end

	// Element being inserted.
	always_ff @(posedge clk) begin
		v_q <= v_d;
	end

	// Next state, store access and output loading.
	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		ovf_d     = ovf_q;
		last_d    = last_q;
		pos_d     = pos_q;
		v_d       = v_q;
		wr_en     = 1'b0;
		wr_addr   = pos_q;
		wr_data   = rd_data;
		rd_en     = 1'b0;
		rd_addr   = pos_q - AW'(1);
		emit.load = 1'b0;
		emit.fin  = fin;
		emit.drop = fin && ovf_q;

		unique case (state_q)
			intsort_pkg::ST_IDLE: begin
				if (accept) begin
					if (full) begin
						// No room left: the element is lost.
						ovf_d = 1'b1;
						if (last) begin
							state_d = intsort_pkg::ST_EMIT_RD;
						end
					end else if (count_q == '0) begin
						// First element goes straight to the bottom entry.
						wr_en   = 1'b1;
						wr_addr = '0;
						wr_data = v_in;
						count_d = CW'(1);
						if (last) begin
							state_d = intsort_pkg::ST_EMIT_RD;
						end
					end else begin
						// Start the walk at the current top entry.
						rd_en   = 1'b1;
						rd_addr = AW'(last_idx);
						pos_d   = AW'(count_q);
						count_d = count_q + CW'(1);
						v_d     = v_in;
						last_d  = last;
						state_d = intsort_pkg::ST_SHIFT;
					end
				end
			end

			intsort_pkg::ST_SHIFT: begin
				wr_en = 1'b1;
				if (gt) begin
					// Larger entry moves up one place.
					wr_data = rd_data;
					pos_d   = pos_q - AW'(1);
					if (pos_q == AW'(1)) begin
						state_d = intsort_pkg::ST_PLACE;
					end else begin
						rd_en   = 1'b1;
						rd_addr = pos_q - AW'(2);
					end
				end else begin
					// Found the place of the new element.
					wr_data = v_q;
					state_d = last_q ? intsort_pkg::ST_EMIT_RD : intsort_pkg::ST_IDLE;
				end
			end

			intsort_pkg::ST_PLACE: begin
				wr_en   = 1'b1;
				wr_data = v_q;
				state_d = last_q ? intsort_pkg::ST_EMIT_RD : intsort_pkg::ST_IDLE;
			end

			intsort_pkg::ST_EMIT_RD: begin
				rd_en   = 1'b1;
				rd_addr = idx_q;
				state_d = intsort_pkg::ST_EMIT;
			end

			intsort_pkg::ST_EMIT: begin
				if (out_free) begin
					emit.load = 1'b1;
					if (fin) begin
						// List done: start a fresh one.
						count_d = '0;
						ovf_d   = 1'b0;
						idx_d   = '0;
						state_d = intsort_pkg::ST_IDLE;
					end else begin
						idx_d   = idx_q + AW'(1);
						rd_en   = 1'b1;
						rd_addr = idx_q + AW'(1);
					end
				end
			end

			default: begin
				state_d = intsort_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/integer_sort_ascending.sv
// ----------------------------------------------------------------------------
// integer_sort_ascending: ascending sort of a list of signed integers
//
// Use: the sender presents one element per transfer on value, with last set
// on the final element of the list. After the final element the block
// returns the list in ascending order on value_res, one transfer per element,
// with last_res set on the largest one. dropped is set on that final result
// when elements arrived beyond CAPACITY and were discarded.
// Each element is inserted by one compare unit walking down the store, one
// entry per cycle: in_stall stays high while an element walks down past the
// larger entries (ST_SHIFT) and is written to its place, so the next element
// waits for that. The first element of a list, and an element that a full
// store discards, raise no stall and the next can follow in the next cycle.
// After the final element has been placed, the first result is read from the
// store in ST_EMIT_RD and loaded in ST_EMIT, then one result per cycle while
// out_stall is low; the store read port sets that rate. A waiting result
// holds in the output register while out_stall is high and the store read
// pauses. The next list is accepted once the final result has been loaded.
// Reset empties the list at once; the store needs no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_sort_ascending #(
	parameter int CAPACITY   = intsort_pkg::CAPACITY_DEF,
	parameter int VALUE_BITS = intsort_pkg::VALUE_BITS_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     in_valid,
	output logic                                          in_stall,
	input  wire logic signed [intsort_pkg::PORT_BITS-1:0] value,
	input  wire logic                                     last,
	output logic                                          out_valid,
	input  wire logic                                     out_stall,
	output logic signed      [intsort_pkg::PORT_BITS-1:0] value_res,
	output logic                                          last_res,
	output logic                                          dropped
);

	localparam int MW = (VALUE_BITS > intsort_pkg::PORT_BITS) ?
		VALUE_BITS : intsort_pkg::PORT_BITS;

	intsort_pkg::emit_t   emit;
	logic [VALUE_BITS-1:0] emit_data;
	logic [MW-1:0]         out_wide;
	logic                  out_free;
	logic                  out_valid_q;
	logic [intsort_pkg::PORT_BITS-1:0] value_res_q;
	logic                  last_res_q;
	logic                  dropped_q;

	intsort_seq #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.value     (value),
		.last      (last),
		.out_free  (out_free),
		.emit      (emit),
		.emit_data (emit_data)
	);

	// The output register takes a new result when empty or being drained.
	assign out_free = !out_valid_q || !out_stall;
	assign out_wide = MW'(emit_data);

	// Output valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (emit.load) begin
			value_res_q <= out_wide[intsort_pkg::PORT_BITS-1:0];
			last_res_q  <= emit.fin;
			dropped_q   <= emit.drop;
		end
	end

	assign out_valid = out_valid_q;
	assign value_res = $signed(value_res_q);
	assign last_res  = last_res_q;
	assign dropped   = dropped_q;

endmodule

`default_nettype wire
